[sv/dhs_pkg.sv]
// ----------------------------------------------------------------------------
// dhs_pkg
// shared types and constants of the double hashed open addressing key set
// ----------------------------------------------------------------------------
package dhs_pkg;

    localparam int KEY_W  = 64;
    localparam int LEN_W  = 4;
    localparam int CHAR_W = 8;
    localparam int MULT_W = 8;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic CFG_FIRST_MULT  = 1'b0;
    localparam logic CFG_SECOND_MULT = 1'b1;

    localparam logic [MULT_W-1:0] FIRST_MULT_RESET  = 8'd3;
    localparam logic [MULT_W-1:0] SECOND_MULT_RESET = 8'd5;

    typedef struct packed {
        logic              tomb;
        logic              used;
        logic [LEN_W-1:0]  len;
        logic [KEY_W-1:0]  key;
    } entry_t;

    typedef struct packed {
        logic              start;
        logic [LEN_W-1:0]  len;
        logic [KEY_W-1:0]  key;
    } hash_req_t;

endpackage

[sv/dhs_ram.sv]
// ----------------------------------------------------------------------------
// dhs_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module dhs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/dhs_hash.sv]
// ----------------------------------------------------------------------------
// dhs_hash
// iterative polynomial hash unit, one character per cycle, both hashes at once
// ----------------------------------------------------------------------------
module dhs_hash #(
    parameter int IW = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dhs_pkg::hash_req_t          req,
    input  logic [IW-1:0]               mask,
    input  logic [dhs_pkg::MULT_W-1:0]  m1,
    input  logic [dhs_pkg::MULT_W-1:0]  m2,
    output logic                        done,
    output logic [IW-1:0]               h1,
    output logic [IW-1:0]               h2
);

    localparam int PW = IW + dhs_pkg::MULT_W + 1;

    logic                         run_reg, run_next;
    logic                         done_reg, done_next;
    logic [dhs_pkg::LEN_W-1:0]    cnt_reg, cnt_next;
    logic [dhs_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [dhs_pkg::KEY_W-1:0]    key_reg, key_next;
    logic [IW-1:0]                g1_reg, g1_next;
    logic [IW-1:0]                g2_reg, g2_next;
    logic [dhs_pkg::CHAR_W-1:0]   c;
    logic [PW-1:0]                p1, p2;
    logic                         last;

    assign c    = key_reg[dhs_pkg::CHAR_W-1:0];
    assign p1   = PW'(g1_reg) * PW'(m1) + PW'(c);
    assign p2   = PW'(g2_reg) * PW'(m2) + PW'(c);
    assign last = (cnt_reg + 4'd1) == len_reg;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        len_next  = len_reg;
        key_next  = key_reg;
        g1_next   = g1_reg;
        g2_next   = g2_reg;
        if (req.start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            len_next = req.len;
            key_next = req.key;
            g1_next  = '0;
            g2_next  = '0;
        end
        else if (run_reg)
        begin
            g1_next  = p1[IW-1:0] & mask;
            g2_next  = p2[IW-1:0] & mask;
            key_next = key_reg >> dhs_pkg::CHAR_W;
            cnt_next = cnt_reg + 4'd1;
            if (last)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        key_reg <= key_next;
        g1_reg  <= g1_next;
        g2_reg  <= g2_next;
    end

    assign done = done_reg;
    assign h1   = g1_reg;
    assign h2   = {g2_reg[IW-2:0], 1'b1} & mask;

endmodule

[sv/double_hash_open_address_set_unit.sv]
// ----------------------------------------------------------------------------
// double_hash_open_address_set_unit
// key set in an open addressed table with double hashing and table doubling
//
// channel   dir  handshake            payload
// in        in   in_valid/in_stall    mode, key_chars, key_length
// out       out  out_valid/out_stall  ok
// cfg       in   cfg_write            cfg_index, cfg_data
//
// a request is hashed, then probes the slots through the single table read
// port, then posts its result; an insert first walks the probe sequence to
// look the key up and then walks it again to place it. a growth clears the
// new table of twice the size, reads every old slot through the same read
// port and hashes and reinserts each used slot, tombstones included, then
// the pending key is hashed again. after reset a pass over INITIAL_SLOTS
// slots clears the table; no transfer is taken meanwhile. a result waiting
// on out_stall does not stop the next input transfer.
// ----------------------------------------------------------------------------
module double_hash_open_address_set_unit #(
    parameter int MAX_SLOTS     = 1024,
    parameter int INITIAL_SLOTS = 8,
    parameter int MAX_KEY_CHARS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  mode,
    input  logic [dhs_pkg::KEY_W-1:0]   key_chars,
    input  logic [dhs_pkg::LEN_W-1:0]   key_length,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        ok,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [dhs_pkg::MULT_W-1:0]  cfg_data
);

    localparam int IW       = $clog2(MAX_SLOTS);
    localparam int CW       = IW + 1;
    localparam int SLW      = $clog2(IW + 1);
    localparam int LOG_INIT = $clog2(INITIAL_SLOTS);
    localparam int EW       = $bits(dhs_pkg::entry_t);

    typedef enum logic [13:0] {
        S_CLR   = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_HASH  = 14'b00000000000100,
        S_FRD   = 14'b00000000001000,
        S_FCK   = 14'b00000000010000,
        S_IRD   = 14'b00000000100000,
        S_ICK   = 14'b00000001000000,
        S_GCLR  = 14'b00000010000000,
        S_GRD   = 14'b00000100000000,
        S_GCK   = 14'b00001000000000,
        S_GHASH = 14'b00010000000000,
        S_GPRD  = 14'b00100000000000,
        S_GPCK  = 14'b01000000000000,
        S_FIN   = 14'b10000000000000
    } state_t;

    state_t                       state_reg, state_next;
    logic [1:0]                   mode_reg, mode_next;
    logic [dhs_pkg::KEY_W-1:0]    key_reg, key_next;
    logic [dhs_pkg::LEN_W-1:0]    len_reg, len_next;
    logic                         bank_reg, bank_next;
    logic [SLW-1:0]               size_log_reg, size_log_next;
    logic [CW-1:0]                live_reg, live_next;
    logic [IW-1:0]                a_reg, a_next;
    logic [IW-1:0]                b_reg, b_next;
    logic [IW-1:0]                s_reg, s_next;
    logic [CW-1:0]                i_reg, i_next;
    logic [CW-1:0]                src_reg, src_next;
    dhs_pkg::entry_t              ent_reg, ent_next;
    logic                         grown_reg, grown_next;
    logic                         res_reg, res_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         ok_reg, ok_next;
    logic [IW-1:0]                hmask_reg, hmask_next;
    logic [dhs_pkg::MULT_W-1:0]   m1_reg, m2_reg;

    logic [CW-1:0]                cur_cap, new_cap;
    logic [IW-1:0]                cur_mask, new_mask;
    logic                         grow_due;
    logic [dhs_pkg::KEY_W-1:0]    in_key;
    logic                         bad_req;

    logic                         wr_en;
    logic [IW:0]                  wr_addr, rd_addr;
    dhs_pkg::entry_t              wr_data, rd_ent;
    logic [EW-1:0]                rd_data;

    dhs_pkg::hash_req_t           hreq;
    logic                         hdone;
    logic [IW-1:0]                h1, h2;

    assign cur_cap  = CW'(1) << size_log_reg;
    assign new_cap  = cur_cap << 1;
    assign cur_mask = IW'(cur_cap - CW'(1));
    assign new_mask = {cur_mask[IW-2:0], 1'b1};
    assign grow_due = ((CW+2)'(live_reg) << 2) > ((CW+2)'(cur_cap) + ((CW+2)'(cur_cap) << 1))
                      && (size_log_reg != SLW'(IW));
    assign rd_ent   = dhs_pkg::entry_t'(rd_data);

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            in_key[k*8 +: 8] = (k < int'(key_length)) ? key_chars[k*8 +: 8] : 8'd0;
        end
    end

    assign bad_req = (key_length == '0) || (key_length > dhs_pkg::LEN_W'(MAX_KEY_CHARS))
                     || (mode == dhs_pkg::MODE_UNUSED);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        key_next       = key_reg;
        len_next       = len_reg;
        bank_next      = bank_reg;
        size_log_next  = size_log_reg;
        live_next      = live_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        s_next         = s_reg;
        i_next         = i_reg;
        src_next       = src_reg;
        ent_next       = ent_reg;
        grown_next     = grown_reg;
        res_next       = res_reg;
        hmask_next     = hmask_reg;
        out_valid_next = out_valid_reg && out_stall;
        ok_next        = ok_reg;
        wr_en          = 1'b0;
        wr_addr        = {bank_reg, s_reg};
        wr_data        = '0;
        rd_addr        = {bank_reg, s_reg};
        hreq           = '0;

        unique case (state_reg)
            S_CLR:
            begin
                wr_en    = 1'b1;
                wr_addr  = {1'b0, src_reg[IW-1:0]};
                src_next = src_reg + CW'(1);
                if (src_reg == CW'(INITIAL_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = mode;
                    key_next   = in_key;
                    len_next   = key_length;
                    grown_next = 1'b0;
                    if (bad_req)
                    begin
                        res_next   = 1'b0;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        hreq.start = 1'b1;
                        hreq.key   = in_key;
                        hreq.len   = key_length;
                        hmask_next = cur_mask;
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                if (hdone)
                begin
                    a_next     = h1;
                    b_next     = h2;
                    s_next     = h1;
                    i_next     = '0;
                    state_next = grown_reg ? S_IRD : S_FRD;
                end
            end
            S_FRD:
            begin
                state_next = S_FCK;
            end
            S_FCK:
            begin
                if (rd_ent.used && !rd_ent.tomb && rd_ent.len == len_reg
                    && rd_ent.key == key_reg)
                begin
                    res_next   = (mode_reg != dhs_pkg::MODE_INSERT);
                    state_next = S_FIN;
                    if (mode_reg == dhs_pkg::MODE_DELETE)
                    begin
                        wr_en     = 1'b1;
                        wr_data   = rd_ent;
                        wr_data.tomb = 1'b1;
                        live_next = live_reg - CW'(1);
                    end
                end
                else if (!rd_ent.used || (i_reg + CW'(1)) == cur_cap)
                begin
                    res_next   = 1'b0;
                    state_next = S_FIN;
                    if (mode_reg == dhs_pkg::MODE_INSERT)
                    begin
                        if (grow_due)
                        begin
                            src_next   = '0;
                            state_next = S_GCLR;
                        end
                        else
                        begin
                            s_next     = a_reg;
                            i_next     = '0;
                            state_next = S_IRD;
                        end
                    end
                end
                else
                begin
                    s_next     = (s_reg + b_reg) & cur_mask;
                    i_next     = i_reg + CW'(1);
                    state_next = S_FRD;
                end
            end
            S_IRD:
            begin
                state_next = S_ICK;
            end
            S_ICK:
            begin
                if (!rd_ent.used || rd_ent.tomb)
                begin
                    wr_en        = 1'b1;
                    wr_data.key  = key_reg;
                    wr_data.len  = len_reg;
                    wr_data.used = 1'b1;
                    wr_data.tomb = 1'b0;
                    live_next    = live_reg + CW'(1);
                    res_next     = 1'b1;
                    state_next   = S_FIN;
                end
                else if ((i_reg + CW'(1)) == cur_cap)
                begin
                    res_next   = 1'b0;
                    state_next = S_FIN;
                end
                else
                begin
                    s_next     = (s_reg + b_reg) & cur_mask;
                    i_next     = i_reg + CW'(1);
                    state_next = S_IRD;
                end
            end
            S_GCLR:
            begin
                wr_en    = 1'b1;
                wr_addr  = {~bank_reg, src_reg[IW-1:0]};
                src_next = src_reg + CW'(1);
                if (src_reg == new_cap - CW'(1))
                begin
                    src_next   = '0;
                    state_next = S_GRD;
                end
            end
            S_GRD:
            begin
                rd_addr    = {bank_reg, src_reg[IW-1:0]};
                state_next = S_GCK;
            end
            S_GCK:
            begin
                ent_next = rd_ent;
                if (rd_ent.used)
                begin
                    hreq.start = 1'b1;
                    hreq.key   = rd_ent.key;
                    hreq.len   = rd_ent.len;
                    hmask_next = new_mask;
                    state_next = S_GHASH;
                end
                else if (src_reg == cur_cap - CW'(1))
                begin
                    bank_next     = ~bank_reg;
                    size_log_next = size_log_reg + SLW'(1);
                    grown_next    = 1'b1;
                    hreq.start    = 1'b1;
                    hreq.key      = key_reg;
                    hreq.len      = len_reg;
                    hmask_next    = new_mask;
                    state_next    = S_HASH;
                end
                else
                begin
                    src_next   = src_reg + CW'(1);
                    state_next = S_GRD;
                end
            end
            S_GHASH:
            begin
                if (hdone)
                begin
                    s_next     = h1;
                    b_next     = h2;
                    state_next = S_GPRD;
                end
            end
            S_GPRD:
            begin
                rd_addr    = {~bank_reg, s_reg};
                state_next = S_GPCK;
            end
            S_GPCK:
            begin
                if (!rd_ent.used)
                begin
                    wr_en   = 1'b1;
                    wr_addr = {~bank_reg, s_reg};
                    wr_data = ent_reg;
                    if (src_reg == cur_cap - CW'(1))
                    begin
                        bank_next     = ~bank_reg;
                        size_log_next = size_log_reg + SLW'(1);
                        grown_next    = 1'b1;
                        hreq.start    = 1'b1;
                        hreq.key      = key_reg;
                        hreq.len      = len_reg;
                        hmask_next    = new_mask;
                        state_next    = S_HASH;
                    end
                    else
                    begin
                        src_next   = src_reg + CW'(1);
                        state_next = S_GRD;
                    end
                end
                else
                begin
                    s_next     = (s_reg + b_reg) & new_mask;
                    state_next = S_GPRD;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    ok_next        = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            bank_reg      <= 1'b0;
            size_log_reg  <= SLW'(LOG_INIT);
            live_reg      <= '0;
            src_reg       <= '0;
            grown_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            m1_reg        <= dhs_pkg::FIRST_MULT_RESET;
            m2_reg        <= dhs_pkg::SECOND_MULT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            size_log_reg  <= size_log_next;
            live_reg      <= live_next;
            src_reg       <= src_next;
            grown_reg     <= grown_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write && cfg_index == dhs_pkg::CFG_FIRST_MULT)
            begin
                m1_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == dhs_pkg::CFG_SECOND_MULT)
            begin
                m2_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        key_reg   <= key_next;
        len_reg   <= len_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        s_reg     <= s_next;
        i_reg     <= i_next;
        ent_reg   <= ent_next;
        res_reg   <= res_next;
        ok_reg    <= ok_next;
        hmask_reg <= hmask_next;
    end

    dhs_hash #(
        .IW (IW)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hreq),
        .mask  (hmask_reg),
        .m1    (m1_reg),
        .m2    (m2_reg),
        .done  (hdone),
        .h1    (h1),
        .h2    (h2)
    );

    dhs_ram #(
        .WIDTH (EW),
        .DEPTH (2 * MAX_SLOTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= cur_cap)
        else $error("live count above table size");

    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        size_log_reg <= SLW'(IW))
        else $error("table size above maximum");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !wr_en)
        else $error("table write while idle");

    a_hash_to_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HASH && hdone) |=> (state_reg == S_FRD || state_reg == S_IRD))
        else $error("hash result not followed by a probe");

endmodule
